// ===== hw/rtl/indexed_min_heap_decrease_key_unit_macros.svh =====
// Assertion macros for the heap unit; expect clk_i and rst_ni in scope.
`ifndef INDEXED_MIN_HEAP_DECREASE_KEY_UNIT_MACROS_SVH
`define INDEXED_MIN_HEAP_DECREASE_KEY_UNIT_MACROS_SVH

// Check while out of reset.
`define IMHDK_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check on every edge, reset included.
`define IMHDK_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

// ===== hw/rtl/imhdk_pkg.sv =====
package imhdk_pkg;

  localparam int unsigned NODE_W  = 8;
  localparam int unsigned COST_W  = 32;
  localparam int unsigned COUNT_W = 9;

  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POP  = 1'b1
  } op_e;

  typedef struct packed {
    logic [NODE_W-1:0]        node;
    logic signed [COST_W-1:0] cost;
  } slot_t;

  localparam int unsigned SLOT_W = $bits(slot_t);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PUSH_POS,
    ST_PUSH_COST,
    ST_UP_CMP,
    ST_POP_ROOT,
    ST_POP_LAST,
    ST_DN_L,
    ST_DN_R,
    ST_FIN,
    ST_DONE
  } state_e;

endpackage

// ===== hw/rtl/imhdk_req_if.sv =====
interface imhdk_req_if;
  logic                                valid;
  logic                                ready;
  logic                                operation;
  logic [imhdk_pkg::NODE_W-1:0]        node;
  logic signed [imhdk_pkg::COST_W-1:0] cost;

  modport source (output valid, operation, node, cost, input ready);
  modport sink (input valid, operation, node, cost, output ready);
endinterface

// ===== hw/rtl/imhdk_rsp_if.sv =====
interface imhdk_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          changed;
  logic [imhdk_pkg::NODE_W-1:0]  popped_node;
  logic                          empty_error;
  logic [imhdk_pkg::COUNT_W-1:0] count;

  modport source (output valid, changed, popped_node, empty_error, count, input ready);
  modport sink (input valid, changed, popped_node, empty_error, count, output ready);
endinterface

// ===== hw/rtl/indexed_min_heap_decrease_key_unit.sv =====
// Indexed binary min-heap with decrease-key over node numbers below NODES.
// req_i (valid/ready) carries one beat per operation: operation 0 pushes
// node with cost (insert when absent, lower the cost when strictly lower),
// operation 1 pops the least-cost node. rsp_o returns one beat per request
// with changed, popped_node, empty_error and the heap count afterwards.
// Heap slots live in one RAM and the node position map in another, both with
// one write port and one registered read port. One request is in work at a
// time. A push does one slot read per level on the sift-up path, up to 8
// levels. A pop does up to two slot reads per level on the sift-down path
// (left child, then right child), so the single read port of the slot RAM
// sets the rate. The response sits in an output register; req_i.ready
// returns while it waits, so the next request runs while the receiver
// stalls, and a finished result is held until the register frees up. After
// reset the position map is swept to absent, one entry per cycle, with
// ready low.
`include "indexed_min_heap_decrease_key_unit_macros.svh"

module indexed_min_heap_decrease_key_unit #(
  parameter int unsigned NODES = 256
) (
  input logic         clk_i,
  input logic         rst_ni,
  imhdk_req_if.sink   req_i,
  imhdk_rsp_if.source rsp_o
);

  localparam int unsigned PDEPTH =
    (NODES < (1 << imhdk_pkg::NODE_W)) ? NODES : (1 << imhdk_pkg::NODE_W);
  localparam int unsigned IDX_W  = $clog2(PDEPTH);
  localparam int unsigned SZ_W   = $clog2(PDEPTH + 1);
  localparam int unsigned CW     = IDX_W + 2;
  localparam int unsigned POS_W  = IDX_W + 1;
  localparam int unsigned CNT_W  = imhdk_pkg::COUNT_W;

  function automatic logic [IDX_W-1:0] parent_of(input logic [IDX_W-1:0] i);
    return (i - IDX_W'(1)) >> 1;
  endfunction

  imhdk_pkg::state_e state_q, state_d;
  logic [SZ_W-1:0]   size_q, size_d;
  imhdk_pkg::slot_t  mv_q, mv_d;
  imhdk_pkg::slot_t  left_q, left_d;
  logic [IDX_W-1:0]  hole_q, hole_d;
  logic              changed_q, changed_d;
  logic [imhdk_pkg::NODE_W-1:0] popped_q, popped_d;
  logic              err_q, err_d;
  logic              clr_busy_q, clr_busy_d;
  logic [IDX_W-1:0]  clr_addr_q, clr_addr_d;
  logic              rsp_valid_q, rsp_valid_d;
  logic              rsp_changed_q;
  logic [imhdk_pkg::NODE_W-1:0] rsp_popped_q;
  logic              rsp_err_q;
  logic [CNT_W-1:0]  rsp_count_q;
  logic              load_rsp;

  logic              slot_we, slot_re;
  logic [IDX_W-1:0]  slot_waddr, slot_raddr;
  imhdk_pkg::slot_t  slot_wdata, slot_rdata;
  logic              pos_we, pos_re;
  logic [IDX_W-1:0]  pos_waddr, pos_raddr;
  logic [POS_W-1:0]  pos_wdata, pos_rdata;

  logic              accept;
  logic              in_range;
  logic              pos_hit;
  logic [IDX_W-1:0]  pos_idx;
  logic [IDX_W-1:0]  size_idx;
  logic [IDX_W-1:0]  up_idx;
  logic [CW-1:0]     size_w, left_w, right_w, next_left_w;
  logic              pick_right;
  imhdk_pkg::slot_t  cand;
  logic [IDX_W-1:0]  cand_idx;
  logic              cand_lower;

  imhdk_ram #(
    .WIDTH (imhdk_pkg::SLOT_W),
    .DEPTH (PDEPTH)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (slot_re),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  imhdk_ram #(
    .WIDTH (POS_W),
    .DEPTH (PDEPTH)
  ) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .waddr_i (pos_waddr),
    .wdata_i (pos_wdata),
    .re_i    (pos_re),
    .raddr_i (pos_raddr),
    .rdata_o (pos_rdata)
  );

  assign req_i.ready = (state_q == imhdk_pkg::ST_IDLE) && !clr_busy_q;
  assign accept      = req_i.valid && req_i.ready;
  assign in_range    = 32'(req_i.node) < NODES;

  assign pos_hit  = pos_rdata[POS_W-1];
  assign pos_idx  = pos_rdata[IDX_W-1:0];
  assign size_idx = size_q[IDX_W-1:0];
  assign up_idx   = parent_of(hole_q);

  assign size_w  = CW'(size_q);
  assign left_w  = {1'b0, hole_q, 1'b1};
  assign right_w = left_w + CW'(1);

  assign pick_right = (state_q == imhdk_pkg::ST_DN_R) && (slot_rdata.cost < left_q.cost);
  assign cand       = ((state_q == imhdk_pkg::ST_DN_L) || pick_right) ? slot_rdata : left_q;
  assign cand_idx   = pick_right ? right_w[IDX_W-1:0] : left_w[IDX_W-1:0];
  assign cand_lower = cand.cost < mv_q.cost;
  assign next_left_w = {1'b0, cand_idx, 1'b1};

  always_comb begin
    state_d     = state_q;
    size_d      = size_q;
    mv_d        = mv_q;
    left_d      = left_q;
    hole_d      = hole_q;
    changed_d   = changed_q;
    popped_d    = popped_q;
    err_d       = err_q;
    clr_busy_d  = clr_busy_q;
    clr_addr_d  = clr_addr_q;
    load_rsp    = 1'b0;
    slot_we     = 1'b0;
    slot_waddr  = hole_q;
    slot_wdata  = mv_q;
    slot_re     = 1'b0;
    slot_raddr  = '0;
    pos_we      = 1'b0;
    pos_waddr   = mv_q.node[IDX_W-1:0];
    pos_wdata   = {1'b1, hole_q};
    pos_re      = 1'b0;
    pos_raddr   = req_i.node[IDX_W-1:0];

    if (clr_busy_q) begin
      pos_we     = 1'b1;
      pos_waddr  = clr_addr_q;
      pos_wdata  = '0;
      clr_addr_d = clr_addr_q + IDX_W'(1);
      if (clr_addr_q == IDX_W'(PDEPTH - 1)) begin
        clr_busy_d = 1'b0;
      end
    end

    unique case (state_q)
      imhdk_pkg::ST_IDLE: begin
        if (accept) begin
          mv_d      = '{node: req_i.node, cost: req_i.cost};
          changed_d = 1'b0;
          popped_d  = '0;
          err_d     = 1'b0;
          if (req_i.operation == imhdk_pkg::OP_POP) begin
            if (size_q == '0) begin
              err_d   = 1'b1;
              state_d = imhdk_pkg::ST_DONE;
            end else begin
              slot_re    = 1'b1;
              slot_raddr = '0;
              state_d    = imhdk_pkg::ST_POP_ROOT;
            end
          end else if (in_range) begin
            pos_re  = 1'b1;
            state_d = imhdk_pkg::ST_PUSH_POS;
          end else begin
            state_d = imhdk_pkg::ST_DONE;
          end
        end
      end
      imhdk_pkg::ST_PUSH_POS: begin
        if (pos_hit) begin
          hole_d     = pos_idx;
          slot_re    = 1'b1;
          slot_raddr = pos_idx;
          state_d    = imhdk_pkg::ST_PUSH_COST;
        end else begin
          hole_d    = size_idx;
          size_d    = size_q + SZ_W'(1);
          changed_d = 1'b1;
          if (size_idx == '0) begin
            state_d = imhdk_pkg::ST_FIN;
          end else begin
            slot_re    = 1'b1;
            slot_raddr = parent_of(size_idx);
            state_d    = imhdk_pkg::ST_UP_CMP;
          end
        end
      end
      imhdk_pkg::ST_PUSH_COST: begin
        if (mv_q.cost < slot_rdata.cost) begin
          changed_d = 1'b1;
          if (hole_q == '0) begin
            state_d = imhdk_pkg::ST_FIN;
          end else begin
            slot_re    = 1'b1;
            slot_raddr = up_idx;
            state_d    = imhdk_pkg::ST_UP_CMP;
          end
        end else begin
          state_d = imhdk_pkg::ST_DONE;
        end
      end
      imhdk_pkg::ST_UP_CMP: begin
        if (mv_q.cost < slot_rdata.cost) begin
          slot_we    = 1'b1;
          slot_waddr = hole_q;
          slot_wdata = slot_rdata;
          pos_we     = 1'b1;
          pos_waddr  = slot_rdata.node[IDX_W-1:0];
          pos_wdata  = {1'b1, hole_q};
          hole_d     = up_idx;
          if (up_idx == '0) begin
            state_d = imhdk_pkg::ST_FIN;
          end else begin
            slot_re    = 1'b1;
            slot_raddr = parent_of(up_idx);
          end
        end else begin
          state_d = imhdk_pkg::ST_FIN;
        end
      end
      imhdk_pkg::ST_POP_ROOT: begin
        popped_d   = slot_rdata.node;
        changed_d  = 1'b1;
        pos_we     = 1'b1;
        pos_waddr  = slot_rdata.node[IDX_W-1:0];
        pos_wdata  = '0;
        size_d     = size_q - SZ_W'(1);
        slot_re    = 1'b1;
        slot_raddr = IDX_W'(size_q - SZ_W'(1));
        state_d    = imhdk_pkg::ST_POP_LAST;
      end
      imhdk_pkg::ST_POP_LAST: begin
        mv_d   = slot_rdata;
        hole_d = '0;
        if (size_q == '0) begin
          state_d = imhdk_pkg::ST_DONE;
        end else if (CW'(1) < size_w) begin
          slot_re    = 1'b1;
          slot_raddr = IDX_W'(1);
          state_d    = imhdk_pkg::ST_DN_L;
        end else begin
          state_d = imhdk_pkg::ST_FIN;
        end
      end
      imhdk_pkg::ST_DN_L,
      imhdk_pkg::ST_DN_R: begin
        if (state_q == imhdk_pkg::ST_DN_L && right_w < size_w) begin
          left_d     = slot_rdata;
          slot_re    = 1'b1;
          slot_raddr = right_w[IDX_W-1:0];
          state_d    = imhdk_pkg::ST_DN_R;
        end else if (cand_lower) begin
          slot_we    = 1'b1;
          slot_waddr = hole_q;
          slot_wdata = cand;
          pos_we     = 1'b1;
          pos_waddr  = cand.node[IDX_W-1:0];
          pos_wdata  = {1'b1, hole_q};
          hole_d     = cand_idx;
          if (next_left_w < size_w) begin
            slot_re    = 1'b1;
            slot_raddr = next_left_w[IDX_W-1:0];
            state_d    = imhdk_pkg::ST_DN_L;
          end else begin
            state_d = imhdk_pkg::ST_FIN;
          end
        end else begin
          state_d = imhdk_pkg::ST_FIN;
        end
      end
      imhdk_pkg::ST_FIN: begin
        slot_we    = 1'b1;
        slot_waddr = hole_q;
        slot_wdata = mv_q;
        pos_we     = 1'b1;
        pos_waddr  = mv_q.node[IDX_W-1:0];
        pos_wdata  = {1'b1, hole_q};
        state_d    = imhdk_pkg::ST_DONE;
      end
      imhdk_pkg::ST_DONE: begin
        if (!rsp_valid_q || rsp_o.ready) begin
          load_rsp = 1'b1;
          state_d  = imhdk_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = imhdk_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    rsp_valid_d = rsp_valid_q;
    if (rsp_valid_q && rsp_o.ready) begin
      rsp_valid_d = 1'b0;
    end
    if (load_rsp) begin
      rsp_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= imhdk_pkg::ST_IDLE;
      size_q      <= '0;
      clr_busy_q  <= 1'b1;
      clr_addr_q  <= '0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      size_q      <= size_d;
      clr_busy_q  <= clr_busy_d;
      clr_addr_q  <= clr_addr_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mv_q      <= mv_d;
    left_q    <= left_d;
    hole_q    <= hole_d;
    changed_q <= changed_d;
    popped_q  <= popped_d;
    err_q     <= err_d;
    if (load_rsp) begin
      rsp_changed_q <= changed_q;
      rsp_popped_q  <= popped_q;
      rsp_err_q     <= err_q;
      rsp_count_q   <= CNT_W'(size_q);
    end
  end

  assign rsp_o.valid       = rsp_valid_q;
  assign rsp_o.changed     = rsp_changed_q;
  assign rsp_o.popped_node = rsp_popped_q;
  assign rsp_o.empty_error = rsp_err_q;
  assign rsp_o.count       = rsp_count_q;

  `IMHDK_ASSERT_ALWAYS(a_slot_rw_apart, slot_we && slot_re |-> slot_waddr != slot_raddr, "slot RAM read and write hit the same entry")
  `IMHDK_ASSERT(a_size_held_idle, state_q == imhdk_pkg::ST_IDLE |=> size_q == $past(size_q), "heap size moved while idle")
  `IMHDK_ASSERT(a_empty_pop_beat, rsp_o.valid && rsp_o.empty_error |-> !rsp_o.changed && rsp_o.count == '0, "empty pop beat reports a change")

endmodule

// ===== hw/rtl/imhdk_ram.sv =====
module imhdk_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 256,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sim/indexed_min_heap_decrease_key_unit_test.sv =====
module indexed_min_heap_decrease_key_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HEAP_NODES     = 256;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned CALM_TAIL      = 150;
  localparam int unsigned SETTLE_CYCLES  = 40;

  typedef struct {
    imhdk_pkg::op_e                      operation;
    logic [imhdk_pkg::NODE_W-1:0]        node;
    logic signed [imhdk_pkg::COST_W-1:0] cost;
    bit                                  drain_first;
  } heap_op_t;

  typedef struct packed {
    logic                          changed;
    logic [imhdk_pkg::NODE_W-1:0]  popped_node;
    logic                          empty_error;
    logic [imhdk_pkg::COUNT_W-1:0] count;
  } heap_result_t;

  logic clk_i;
  logic rst_ni;

  imhdk_req_if req_bus ();
  imhdk_rsp_if rsp_bus ();

  indexed_min_heap_decrease_key_unit #(
    .NODES(HEAP_NODES)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (req_bus),
    .rsp_o (rsp_bus)
  );

  heap_op_t     op_backlog[$];
  heap_result_t heap_answers_due[$];

  logic [imhdk_pkg::NODE_W-1:0] heap_node   [HEAP_NODES];
  int                           heap_cost   [HEAP_NODES];
  int unsigned                  node_slot   [HEAP_NODES];
  bit                           node_listed [HEAP_NODES];
  int unsigned                  heap_fill = 0;

  int unsigned errors = 0;
  int unsigned sent_beats = 0;
  int unsigned send_gap = 0;
  int unsigned recv_gap = 0;
  int unsigned quiet_cycles = 0;

  function automatic void heap_swap(int unsigned a, int unsigned b);
    logic [imhdk_pkg::NODE_W-1:0] n;
    int c;
    n = heap_node[a];
    c = heap_cost[a];
    heap_node[a] = heap_node[b];
    heap_cost[a] = heap_cost[b];
    heap_node[b] = n;
    heap_cost[b] = c;
    node_slot[heap_node[a]] = a;
    node_slot[heap_node[b]] = b;
  endfunction

  function automatic void heap_rise(int unsigned start);
    int unsigned i;
    int unsigned p;
    i = start;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (heap_cost[i] < heap_cost[p]) begin
        heap_swap(i, p);
        i = p;
      end else begin
        i = 0;
      end
    end
  endfunction

  function automatic void heap_sink(int unsigned start);
    int unsigned i;
    int unsigned l;
    int unsigned r;
    int unsigned pick;
    bit going;
    i = start;
    going = 1'b1;
    while (going) begin
      l = 2 * i + 1;
      r = l + 1;
      going = 1'b0;
      if (l < heap_fill) begin
        pick = l;
        if (r < heap_fill) begin
          if (heap_cost[r] < heap_cost[l]) pick = r;
        end
        if (heap_cost[pick] < heap_cost[i]) begin
          heap_swap(pick, i);
          i = pick;
          going = 1'b1;
        end
      end
    end
  endfunction

  function automatic heap_result_t heap_apply(logic op, logic [imhdk_pkg::NODE_W-1:0] node,
                                              int cost);
    heap_result_t res;
    int unsigned i;
    res = '0;
    if (op == imhdk_pkg::OP_PUSH) begin
      if (node_listed[node]) begin
        i = node_slot[node];
        if (i < heap_fill && cost < heap_cost[i]) begin
          heap_cost[i] = cost;
          heap_rise(i);
          res.changed = 1'b1;
        end
      end else if (heap_fill < HEAP_NODES) begin
        i = heap_fill;
        heap_node[i] = node;
        heap_cost[i] = cost;
        node_slot[node] = i;
        node_listed[node] = 1'b1;
        heap_fill++;
        heap_rise(i);
        res.changed = 1'b1;
      end
    end else if (heap_fill == 0) begin
      res.empty_error = 1'b1;
    end else begin
      i = heap_fill - 1;
      heap_swap(0, i);
      res.popped_node = heap_node[i];
      heap_fill = i;
      heap_sink(0);
      node_listed[res.popped_node] = 1'b0;
      node_slot[res.popped_node] = 0;
      res.changed = 1'b1;
    end
    res.count = imhdk_pkg::COUNT_W'(heap_fill);
    return res;
  endfunction

  function automatic logic [imhdk_pkg::NODE_W-1:0] rand_node();
    if ($urandom_range(0, 9) < 3) return imhdk_pkg::NODE_W'($urandom_range(0, 15));
    return imhdk_pkg::NODE_W'($urandom_range(0, HEAP_NODES - 1));
  endfunction

  function automatic logic signed [imhdk_pkg::COST_W-1:0] rand_cost();
    case ($urandom_range(0, 9))
      0: begin
        case ($urandom_range(0, 3))
          0: return 32'sh8000_0000;
          1: return 32'sh7fff_ffff;
          2: return -1;
          default: return 0;
        endcase
      end
      1, 2, 3: return int'($urandom_range(0, 16)) - 8;
      default: return $urandom;
    endcase
  endfunction

  function automatic void add_item(imhdk_pkg::op_e op, logic [imhdk_pkg::NODE_W-1:0] node,
                                   logic signed [imhdk_pkg::COST_W-1:0] cost,
                                   bit drain_first);
    heap_op_t item;
    item.operation = op;
    item.node = node;
    item.cost = cost;
    item.drain_first = drain_first;
    op_backlog.push_back(item);
  endfunction

  function automatic void add_mix(int unsigned n);
    int unsigned push_pct;
    imhdk_pkg::op_e op;
    push_pct = 55;
    for (int unsigned k = 0; k < n; k++) begin
      if (k % 64 == 0) begin
        case ($urandom_range(0, 2))
          0: push_pct = 25;
          1: push_pct = 55;
          default: push_pct = 85;
        endcase
      end
      op = ($urandom_range(0, 99) < push_pct) ? imhdk_pkg::OP_PUSH : imhdk_pkg::OP_POP;
      add_item(op, rand_node(), rand_cost(), k == 0 && $urandom_range(0, 3) == 0);
    end
  endfunction

  function automatic void add_fill();
    logic [imhdk_pkg::NODE_W-1:0] order [HEAP_NODES];
    logic [imhdk_pkg::NODE_W-1:0] t;
    int unsigned j;
    for (int unsigned k = 0; k < HEAP_NODES; k++) order[k] = imhdk_pkg::NODE_W'(k);
    for (int unsigned k = HEAP_NODES - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      t = order[k];
      order[k] = order[j];
      order[j] = t;
    end
    for (int unsigned k = 0; k < HEAP_NODES; k++) begin
      add_item(imhdk_pkg::OP_PUSH, order[k], rand_cost(), k == 0);
    end
  endfunction

  function automatic int unsigned idle_chance(int unsigned shift);
    if (op_backlog.size() < CALM_TAIL) return 0;
    case (((sent_beats / 128) + shift) % 4)
      0: return 0;
      1: return 15;
      2: return 40;
      default: return 70;
    endcase
  endfunction

  function automatic void report_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_bus.valid     <= 1'b0;
      req_bus.operation <= imhdk_pkg::OP_PUSH;
      req_bus.node      <= '0;
      req_bus.cost      <= '0;
    end else if (!req_bus.valid || req_bus.ready) begin
      if (req_bus.valid) begin
        heap_answers_due.push_back(heap_apply(req_bus.operation, req_bus.node,
                                              int'(req_bus.cost)));
        sent_beats++;
      end
      if (send_gap == 0 && $urandom_range(0, 99) < idle_chance(0)) begin
        send_gap = $urandom_range(1, 7);
      end
      if (send_gap != 0) begin
        send_gap--;
        req_bus.valid <= 1'b0;
      end else if (op_backlog.size() == 0 ||
                   (op_backlog[0].drain_first && heap_answers_due.size() != 0)) begin
        req_bus.valid <= 1'b0;
      end else begin
        req_bus.valid     <= 1'b1;
        req_bus.operation <= op_backlog[0].operation;
        req_bus.node      <= op_backlog[0].node;
        req_bus.cost      <= op_backlog[0].cost;
        void'(op_backlog.pop_front());
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    heap_result_t want;
    if (!rst_ni) begin
      rsp_bus.ready <= 1'b0;
    end else begin
      if (rsp_bus.valid && rsp_bus.ready) begin
        if (heap_answers_due.size() == 0) begin
          errors++;
          $display("%0t ns: response beat with none expected, actual count %0d",
                   $time, rsp_bus.count);
        end else begin
          want = heap_answers_due.pop_front();
          report_field("changed", want.changed, rsp_bus.changed);
          report_field("popped_node", want.popped_node, rsp_bus.popped_node);
          report_field("empty_error", want.empty_error, rsp_bus.empty_error);
          report_field("count", want.count, rsp_bus.count);
          if ($isunknown({rsp_bus.changed, rsp_bus.popped_node, rsp_bus.empty_error,
                          rsp_bus.count})) begin
            errors++;
            $display("%0t ns: unknown bits in response, expected count %0d, actual %b",
                     $time, want.count, rsp_bus.count);
          end
        end
      end
      if (recv_gap == 0 && $urandom_range(0, 99) < idle_chance(2)) begin
        recv_gap = $urandom_range(1, 7);
      end
      if (recv_gap != 0) begin
        recv_gap--;
        rsp_bus.ready <= 1'b0;
      end else begin
        rsp_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;

    add_item(imhdk_pkg::OP_POP, 8'hff, 32'sh7fff_ffff, 1'b0);
    add_item(imhdk_pkg::OP_PUSH, 8'd0, 32'sh7fff_ffff, 1'b0);
    add_item(imhdk_pkg::OP_PUSH, 8'd255, 32'sh8000_0000, 1'b0);
    add_item(imhdk_pkg::OP_PUSH, 8'd0, 32'sh7fff_ffff, 1'b0);
    add_item(imhdk_pkg::OP_PUSH, 8'd0, 0, 1'b0);
    add_item(imhdk_pkg::OP_PUSH, 8'd0, 5, 1'b0);
    add_item(imhdk_pkg::OP_PUSH, 8'd128, 0, 1'b0);
    add_item(imhdk_pkg::OP_PUSH, 8'd127, 0, 1'b0);
    add_item(imhdk_pkg::OP_PUSH, 8'd85, -1, 1'b0);
    add_item(imhdk_pkg::OP_PUSH, 8'd170, 32'sh0001_0000, 1'b0);
    add_item(imhdk_pkg::OP_PUSH, 8'd255, 32'sh8000_0000, 1'b0);
    add_item(imhdk_pkg::OP_PUSH, 8'd170, 32'sh8000_0000, 1'b0);
    add_item(imhdk_pkg::OP_PUSH, 8'd1, 32'sh7fff_ffff, 1'b0);
    for (int k = 0; k < 8; k++) add_item(imhdk_pkg::OP_POP, rand_node(), rand_cost(), 1'b0);
    add_item(imhdk_pkg::OP_POP, 8'h00, 32'sh8000_0000, 1'b1);

    add_mix(600);
    add_fill();
    add_mix(380);
    for (int k = 0; k < 260; k++) begin
      add_item(imhdk_pkg::OP_POP, rand_node(), rand_cost(), k == 0);
    end
    add_mix(100);

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (op_backlog.size() != 0 || req_bus.valid || heap_answers_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    if (errors == 0 && heap_answers_due.size() == 0 && op_backlog.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
